@@ rtl/mesh_route_table_generator_macros.svh @@
// Assertion macros used by the checker file of the route table generator.
`ifndef MESH_ROUTE_TABLE_GENERATOR_MACROS_SVH
`define MESH_ROUTE_TABLE_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MRTG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("route table generator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MRTG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("route table generator check failed");

`endif

@@ rtl/mrtg_pkg.sv @@
// Shared types, constants and route functions of the mesh route table generator.
package mrtg_pkg;

  localparam int NODE_COUNT = 64;
  localparam int NBYTES     = (NODE_COUNT + 3) / 4;
  localparam int BW         = (NBYTES > 1) ? $clog2(NBYTES) : 1;
  localparam int DW         = BW + 2;
  localparam int CMPW       = 9;
  localparam int SRC_W      = 6;
  localparam int CNT_W      = 3;
  localparam int REG_W      = 7;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;
  localparam int FIFO_DEPTH = 2;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  localparam logic [1:0] REG_MESH_COLS      = 2'd0;
  localparam logic [1:0] REG_MESH_ROWS      = 2'd1;
  localparam logic [1:0] REG_SINGLE_MEM_ROW = 2'd2;

  typedef enum logic [1:0] {
    ROUTE_NORTH = 2'd0,
    ROUTE_EAST  = 2'd1,
    ROUTE_SOUTH = 2'd2,
    ROUTE_WEST  = 2'd3
  } route_t;

  typedef enum logic [2:0] {
    FS_IDLE = 3'b001,
    FS_DIV  = 3'b010,
    FS_PUSH = 3'b100
  } front_state_t;

  // Effective mesh shape: zero columns or rows already read as one.
  typedef struct packed {
    logic [REG_W-1:0] cols;
    logic [REG_W-1:0] rows;
    logic             single_mem_row;
  } cfg_t;

  // Source position after classification, as queued for the back end.
  typedef struct packed {
    logic [SRC_W-1:0] s_col;
    logic [SRC_W-1:0] s_row;
    logic             ew_ok;
  } route_info_t;

  typedef struct packed {
    logic [REG_W-1:0] col;
    logic [DW-1:0]    row;
  } pos_t;

  // Advance a destination position by one node in row-major order.
  function automatic pos_t next_pos(pos_t p, logic [REG_W-1:0] cols);
    pos_t             n;
    logic [REG_W-1:0] col_inc;
    col_inc = REG_W'(p.col + 1'b1);
    if (col_inc == cols) begin
      n.col = '0;
      n.row = DW'(p.row + 1'b1);
    end else begin
      n.col = col_inc;
      n.row = p.row;
    end
    return n;
  endfunction

  function automatic route_t pick_route(route_info_t s, pos_t d);
    logic [REG_W-1:0] s_col_x;
    route_t           r;
    s_col_x = REG_W'(s.s_col);
    if (s.ew_ok && (d.col < s_col_x)) begin
      r = ROUTE_WEST;
    end else if (s.ew_ok && (d.col > s_col_x)) begin
      r = ROUTE_EAST;
    end else if (CMPW'(d.row) > CMPW'(s.s_row)) begin
      r = ROUTE_SOUTH;
    end else begin
      r = ROUTE_NORTH;
    end
    return r;
  endfunction

endpackage

@@ rtl/mrtg_cfg.sv @@
// APB register file holding the mesh shape.
module mrtg_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mrtg_pkg::ADDR_W-1:0]  paddr,
  input  logic [mrtg_pkg::DATA_W-1:0]  pwdata,
  output logic [mrtg_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output mrtg_pkg::cfg_t               cfg
);

  logic [mrtg_pkg::REG_W-1:0] cols_r, cols_nxt;
  logic [mrtg_pkg::REG_W-1:0] rows_r, rows_nxt;
  logic                       smr_r, smr_nxt;
  logic                       wr_en;
  logic [1:0]                 reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cols_nxt = cols_r;
    rows_nxt = rows_r;
    smr_nxt  = smr_r;
    if (wr_en) begin
      unique case (reg_idx)
        mrtg_pkg::REG_MESH_COLS:      cols_nxt = pwdata[mrtg_pkg::REG_W-1:0];
        mrtg_pkg::REG_MESH_ROWS:      rows_nxt = pwdata[mrtg_pkg::REG_W-1:0];
        mrtg_pkg::REG_SINGLE_MEM_ROW: smr_nxt  = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mrtg_pkg::REG_MESH_COLS:      prdata = mrtg_pkg::DATA_W'(cols_r);
      mrtg_pkg::REG_MESH_ROWS:      prdata = mrtg_pkg::DATA_W'(rows_r);
      mrtg_pkg::REG_SINGLE_MEM_ROW: prdata = mrtg_pkg::DATA_W'(smr_r);
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= mrtg_pkg::REG_W'(8);
      rows_r <= mrtg_pkg::REG_W'(8);
      smr_r  <= 1'b0;
    end else begin
      cols_r <= cols_nxt;
      rows_r <= rows_nxt;
      smr_r  <= smr_nxt;
    end
  end

  assign cfg.cols           = (cols_r == '0) ? mrtg_pkg::REG_W'(1) : cols_r;
  assign cfg.rows           = (rows_r == '0) ? mrtg_pkg::REG_W'(1) : rows_r;
  assign cfg.single_mem_row = smr_r;

endmodule

@@ rtl/mrtg_front.sv @@
// Front end: accepts a source node and splits it into row and column.
module mrtg_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mrtg_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mrtg_pkg::SRC_W-1:0]  in_source_node,
  output logic                        push,
  output mrtg_pkg::route_info_t       push_data,
  input  logic                        fifo_full
);

  mrtg_pkg::front_state_t state_r, state_nxt;
  logic [mrtg_pkg::SRC_W-1:0] s_r, s_nxt;
  logic [mrtg_pkg::SRC_W-1:0] q_r, q_nxt;
  logic [mrtg_pkg::REG_W-1:0] rem_r, rem_nxt;
  logic [mrtg_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [mrtg_pkg::REG_W:0]   trial;
  logic                       ge;
  logic [mrtg_pkg::REG_W-1:0] rem_step;
  logic                       accept;

  // One restoring-division step per cycle: node / cols and node % cols.
  assign trial    = {rem_r, s_r[mrtg_pkg::SRC_W-1]};
  assign ge       = trial >= {1'b0, cfg.cols};
  assign rem_step = ge ? mrtg_pkg::REG_W'(trial - {1'b0, cfg.cols})
                       : trial[mrtg_pkg::REG_W-1:0];

  assign push     = (state_r == mrtg_pkg::FS_PUSH) && !fifo_full;
  assign in_ready = (state_r == mrtg_pkg::FS_IDLE) || push;
  assign accept   = in_valid && in_ready;

  assign push_data.s_col = rem_r[mrtg_pkg::SRC_W-1:0];
  assign push_data.s_row = q_r;
  assign push_data.ew_ok = (q_r != '0) &&
                           ((mrtg_pkg::REG_W'(q_r) != mrtg_pkg::REG_W'(cfg.rows - 1'b1)) ||
                            cfg.single_mem_row);

  always_comb begin
    state_nxt = state_r;
    s_nxt     = s_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      mrtg_pkg::FS_IDLE: ;
      mrtg_pkg::FS_DIV: begin
        s_nxt   = {s_r[mrtg_pkg::SRC_W-2:0], 1'b0};
        q_nxt   = {q_r[mrtg_pkg::SRC_W-2:0], ge};
        rem_nxt = rem_step;
        cnt_nxt = mrtg_pkg::CNT_W'(cnt_r + 1'b1);
        if (cnt_r == mrtg_pkg::CNT_W'(mrtg_pkg::SRC_W - 1)) begin
          state_nxt = mrtg_pkg::FS_PUSH;
        end
      end
      mrtg_pkg::FS_PUSH: begin
        if (push) begin
          state_nxt = mrtg_pkg::FS_IDLE;
        end
      end
      default: state_nxt = mrtg_pkg::FS_IDLE;
    endcase
    if (accept) begin
      state_nxt = mrtg_pkg::FS_DIV;
      s_nxt     = in_source_node;
      q_nxt     = '0;
      rem_nxt   = '0;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mrtg_pkg::FS_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r   <= s_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

endmodule

@@ rtl/mrtg_fifo.sv @@
// Two-entry queue of classified sources between front and back end.
module mrtg_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  mrtg_pkg::route_info_t push_data,
  output logic                  full,
  input  logic                  pop,
  output logic                  valid,
  output mrtg_pkg::route_info_t pop_data
);

  mrtg_pkg::route_info_t          mem_r [mrtg_pkg::FIFO_DEPTH];
  logic [mrtg_pkg::FPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [mrtg_pkg::FCNT_W-1:0]    cnt_r, cnt_nxt;

  assign full     = cnt_r == mrtg_pkg::FCNT_W'(mrtg_pkg::FIFO_DEPTH);
  assign valid    = cnt_r != '0;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    priority if (push && !pop) begin
      cnt_nxt = mrtg_pkg::FCNT_W'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = mrtg_pkg::FCNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= mrtg_pkg::FPTR_W'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= mrtg_pkg::FPTR_W'(rd_ptr_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/mrtg_back.sv @@
// Back end: walks the destinations four a cycle unless the output stalls, and emits packed route bytes.
module mrtg_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mrtg_pkg::cfg_t        cfg,
  input  logic                  fifo_valid,
  input  mrtg_pkg::route_info_t fifo_data,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_route_byte,
  output logic                  out_last_byte
);

  logic                       active_r, active_nxt;
  mrtg_pkg::route_info_t      info_r;
  logic [mrtg_pkg::BW-1:0]    b_r;
  mrtg_pkg::pos_t             pos_r;
  logic                       ov_r, ov_nxt;
  logic [7:0]                 byte_r;
  logic                       last_r;
  mrtg_pkg::pos_t             pos [5];
  logic [7:0]                 byte_c;
  logic                       last_c;
  logic                       step_en;
  logic                       finishing;
  logic [mrtg_pkg::DW-1:0]    dest;

  // Four destinations in a chain; the fifth position starts the next byte.
  always_comb begin
    pos[0] = pos_r;
    byte_c = '0;
    dest   = '0;
    for (int k = 0; k < 4; k++) begin
      pos[k+1] = mrtg_pkg::next_pos(pos[k], cfg.cols);
      dest     = {b_r, 2'(k)};
      if (int'(dest) < mrtg_pkg::NODE_COUNT) begin
        byte_c[2*k +: 2] = 2'(mrtg_pkg::pick_route(info_r, pos[k]));
      end
    end
  end

  assign last_c     = b_r == mrtg_pkg::BW'(mrtg_pkg::NBYTES - 1);
  assign step_en    = active_r && (!ov_r || out_ready);
  assign finishing  = step_en && last_c;
  assign pop        = fifo_valid && (!active_r || finishing);

  always_comb begin
    active_nxt = active_r;
    if (pop) begin
      active_nxt = 1'b1;
    end else if (finishing) begin
      active_nxt = 1'b0;
    end
    ov_nxt = ov_r;
    if (step_en) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      active_r <= active_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      byte_r <= byte_c;
      last_r <= last_c;
    end
    if (pop) begin
      info_r <= fifo_data;
      b_r    <= '0;
      pos_r  <= '0;
    end else if (step_en) begin
      b_r   <= mrtg_pkg::BW'(b_r + 1'b1);
      pos_r <= pos[4];
    end
  end

  assign out_valid      = ov_r;
  assign out_route_byte = byte_r;
  assign out_last_byte  = last_r;

endmodule

@@ rtl/mesh_route_table_generator.sv @@
// Top level of the mesh route table generator.
//
// Each request on the input channel names a source node; the block answers
// with that node's XY next-hop table, NODE_COUNT/4 bytes of four 2-bit routes
// each (16 bytes at 64 nodes), the lowest destination in the low bits, and
// out_last_byte set on the final byte.
// The front end splits the node into row and column with a restoring divider,
// one quotient bit per cycle, then hands it to a two-entry queue.
// The back end pops the queue and produces one byte per cycle unless the
// receiver stalls, and tables follow back to back with no gap.
// A stalled receiver holds the current byte in the output register; the back
// end waits, the queue fills, and then in_ready drops.
// Mesh shape sits in APB registers (cols at 0x0, rows at 0x4, single memory
// row at 0x8); write them only while the block is idle.
// Reset (rst_n low, synchronous) empties the pipeline and restores an 8x8
// mesh with two memory-controller rows.
module mesh_route_table_generator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mrtg_pkg::SRC_W-1:0]  in_source_node,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_route_byte,
  output logic                        out_last_byte,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mrtg_pkg::ADDR_W-1:0] paddr,
  input  logic [mrtg_pkg::DATA_W-1:0] pwdata,
  output logic [mrtg_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  mrtg_pkg::cfg_t        cfg;
  logic                  push;
  mrtg_pkg::route_info_t push_data;
  logic                  fifo_full;
  logic                  pop;
  logic                  fifo_valid;
  mrtg_pkg::route_info_t pop_data;

  mrtg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mrtg_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_source_node (in_source_node),
    .push           (push),
    .push_data      (push_data),
    .fifo_full      (fifo_full)
  );

  mrtg_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop       (pop),
    .valid     (fifo_valid),
    .pop_data  (pop_data)
  );

  mrtg_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .fifo_valid     (fifo_valid),
    .fifo_data      (pop_data),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_route_byte (out_route_byte),
    .out_last_byte  (out_last_byte)
  );

endmodule

@@ rtl/mrtg_checker.sv @@
// Port-level checks of the mesh route table generator, bound to the top level.
`include "mesh_route_table_generator_macros.svh"

module mrtg_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [7:0]                  out_route_byte,
  input logic                        out_last_byte
);

  logic [mrtg_pkg::BW-1:0] byte_cnt_r;
  logic [2:0]              pending_r;
  logic                    in_acc;
  logic                    out_acc;
  logic                    tbl_done;

  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  assign tbl_done = out_acc && out_last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r <= '0;
      pending_r  <= '0;
    end else begin
      if (tbl_done) begin
        byte_cnt_r <= '0;
      end else if (out_acc) begin
        byte_cnt_r <= mrtg_pkg::BW'(byte_cnt_r + 1'b1);
      end
      pending_r <= 3'(pending_r + 3'(in_acc) - 3'(tbl_done));
    end
  end

  `MRTG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(out_route_byte) && $stable(out_last_byte))

  // Every table is exactly NBYTES long, the flag on its final byte only.
  `MRTG_ASSERT_NOW(a_last_pos, out_valid,
                   out_last_byte == (byte_cnt_r == mrtg_pkg::BW'(mrtg_pkg::NBYTES - 1)))

  // No byte appears without a request that is still owed its table.
  `MRTG_ASSERT_NOW(a_no_orphan, out_valid, pending_r != 3'd0)

  // Route pairs past the last node in the final byte read as zero.
  `MRTG_ASSERT_NOW(a_pad_zero, out_valid && out_last_byte,
                   ((mrtg_pkg::NODE_COUNT % 4) == 0) ||
                   ((out_route_byte >> (2 * (mrtg_pkg::NODE_COUNT % 4))) == 8'd0))

endmodule

bind mesh_route_table_generator mrtg_checker u_mrtg_checker (.*);
